@@ design/cnav_message_set_assembler_assert.svh @@
// Assertion macros for the message set assembler.
// Each macro expects clk and arst_n in scope.
`ifndef CNAV_MESSAGE_SET_ASSEMBLER_ASSERT_SVH
`define CNAV_MESSAGE_SET_ASSEMBLER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CMSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmsa assertion failed");
// Next-cycle implication.
`define CMSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmsa assertion failed");
`else
`define CMSA_ASSERT_IMP(lbl, ante, cons)
`define CMSA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/cmsa_pkg.sv @@
package cmsa_pkg;

	localparam int WPM       = 10;
	localparam int SLOT_CNT  = 3;
	localparam int MEM_DEPTH = SLOT_CNT * WPM;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int CNT_W     = $clog2(WPM);
	localparam int SLOT_W    = 2;
	localparam int WORD_W    = 30;
	localparam int TYPE_W    = 6;
	localparam int WEEK_W    = 13;
	localparam int TOW_W     = 17;
	localparam int TIME_W    = 20;
	localparam int CFG_W     = 8;

	localparam logic CFG_GAP    = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	localparam logic [TYPE_W-1:0] MT_EPH1   = 6'd10;
	localparam logic [TYPE_W-1:0] MT_EPH2   = 6'd11;
	localparam logic [TYPE_W-1:0] MT_CLK_LO = 6'd30;
	localparam logic [TYPE_W-1:0] MT_CLK_HI = 6'd37;

	localparam logic [SLOT_W-1:0] SLOT_EPH1 = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_EPH2 = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_CLK  = 2'd2;

	typedef enum logic [2:0] {
		ST_DROP     = 3'd0,
		ST_STORED   = 3'd1,
		ST_OTHER    = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_WORD     = 3'd4
	} status_t;

	typedef struct packed {
		logic accept;
		logic fill;
		logic decide;
		logic load_word;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic msg_end;
		logic need_fill;
		logic fill_last;
		logic go_emit;
		logic em_last;
	} dp_sts_t;

endpackage

@@ design/cmsa_ctrl.sv @@
module cmsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cmsa_pkg::dp_cmd_t cmd,
	input  cmsa_pkg::dp_sts_t sts
);
	import cmsa_pkg::*;

	typedef enum logic [2:0] {
		S_IN,
		S_FILL,
		S_DECIDE,
		S_RD,
		S_LOAD,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == S_IN);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.accept    = accept;
		cmd.fill      = (state_q == S_FILL);
		cmd.decide    = (state_q == S_DECIDE) && out_free;
		cmd.load_word = (state_q == S_LOAD);
		cmd.advance   = (state_q == S_HOLD) && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IN;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IN: begin
					if (accept && sts.msg_end)
						state_q <= sts.need_fill ? S_FILL : S_DECIDE;
				end
				S_FILL: begin
					if (sts.fill_last)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_free) begin
						if (sts.go_emit) begin
							state_q <= S_RD;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= S_IN;
						end
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_HOLD;
				end
				S_HOLD: begin
					if (out_ready)
						state_q <= sts.em_last ? S_IN : S_RD;
				end
				default: begin
					state_q <= S_IN;
				end
			endcase
		end
	end

endmodule

@@ design/cmsa_dp.sv @@
module cmsa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [cmsa_pkg::CFG_W-1:0]    cfg_data,
	input  logic [cmsa_pkg::WORD_W-1:0]   nav_word,
	input  logic                          word_last,
	input  cmsa_pkg::dp_cmd_t             cmd,
	output cmsa_pkg::dp_sts_t             sts,
	output logic [2:0]                    status,
	output logic [cmsa_pkg::WORD_W-1:0]   out_word,
	output logic [cmsa_pkg::SLOT_W-1:0]   out_slot,
	output logic                          out_last,
	output logic [cmsa_pkg::TYPE_W-1:0]   msg_type,
	output logic [cmsa_pkg::TYPE_W-1:0]   sat_prn,
	output logic [cmsa_pkg::WEEK_W-1:0]   week_number
);
	import cmsa_pkg::*;

	function automatic logic [MEM_AW-1:0] mem_addr(logic [SLOT_W-1:0] slot,
			logic [CNT_W-1:0] idx);
		mem_addr = MEM_AW'(slot) * MEM_AW'(WPM) + MEM_AW'(idx);
	endfunction

	// configuration
	logic [CFG_W-1:0] gap_q;
	logic [CFG_W-1:0] window_q;

	// message capture
	logic [CNT_W-1:0]  cnt_q;
	logic [TYPE_W-1:0] type_q;
	logic [TYPE_W-1:0] prn_q;
	logic [TOW_W-1:0]  tow_q;
	logic [WEEK_W-1:0] week_hdr_q;
	logic [SLOT_W-1:0] msg_slot_q;
	logic              msg_wr_q;

	// set state
	logic              week_valid_q;
	logic [WEEK_W-1:0] week_q;
	logic [TIME_W-1:0] slot_time_q [SLOT_CNT];
	logic [SLOT_CNT-1:0] slot_valid_q;

	// emission
	logic [SLOT_W-1:0] em_slot_q;
	logic [CNT_W-1:0]  em_idx_q;

	// output register
	status_t           out_status_q;
	logic [WORD_W-1:0] out_word_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_last_q;
	logic [TYPE_W-1:0] out_type_q;
	logic [TYPE_W-1:0] out_prn_q;

	// slot memory
	logic [WORD_W-1:0] mem [MEM_DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic [MEM_AW-1:0] mem_ra;

	// word-0 decode
	logic [TYPE_W-1:0] w_type;
	logic [SLOT_W-1:0] w_slot;
	logic              w_wr;
	logic              wr_now;
	logic [SLOT_W-1:0] slot_now;
	logic              cnt_full;

	// decision
	logic              is10, is11, is3x, hit, week_ok, stored, match;
	logic [SLOT_W-1:0] dec_slot;
	logic [TIME_W-1:0] t_new;
	logic signed [TIME_W:0] d11, d3x;
	status_t           dec_status;

	assign w_type = nav_word[15:10];

	always_comb begin
		if (w_type == MT_EPH1)
			w_slot = SLOT_EPH1;
		else if (w_type == MT_EPH2)
			w_slot = SLOT_EPH2;
		else
			w_slot = SLOT_CLK;
	end

	assign w_wr = (w_type == MT_EPH1) || (week_valid_q && ((w_type == MT_EPH2) ||
		(w_type inside {[MT_CLK_LO:MT_CLK_HI]})));

	assign wr_now   = (cnt_q == '0) ? w_wr : msg_wr_q;
	assign slot_now = (cnt_q == '0) ? w_slot : msg_slot_q;
	assign cnt_full = (cnt_q == CNT_W'(WPM - 1));

	// decision at message end
	assign is10     = (type_q == MT_EPH1);
	assign is11     = (type_q == MT_EPH2);
	assign is3x     = type_q inside {[MT_CLK_LO:MT_CLK_HI]};
	assign hit      = is10 || is11 || is3x;
	assign week_ok  = week_valid_q || is10;
	assign stored   = week_ok && hit;
	assign dec_slot = is10 ? SLOT_EPH1 : (is11 ? SLOT_EPH2 : SLOT_CLK);
	assign t_new    = (TIME_W'(tow_q) << 2) + (TIME_W'(tow_q) << 1);
	assign d11 = $signed({1'b0, slot_time_q[1]}) - $signed({1'b0, slot_time_q[0]});
	assign d3x = $signed({1'b0, t_new}) - $signed({1'b0, slot_time_q[0]});
	assign match = week_ok && is3x && (slot_valid_q[1:0] == 2'b11) &&
		(d11 == $signed({{(TIME_W + 1 - CFG_W){1'b0}}, gap_q})) &&
		(d3x <= $signed({{(TIME_W + 1 - CFG_W){1'b0}}, window_q}));

	always_comb begin
		if (!week_ok)
			dec_status = ST_DROP;
		else if (!hit)
			dec_status = ST_OTHER;
		else if (!is3x)
			dec_status = ST_STORED;
		else if (match)
			dec_status = ST_WORD;
		else
			dec_status = ST_MISMATCH;
	end

	always_comb begin
		sts.msg_end   = word_last || cnt_full;
		sts.need_fill = wr_now && !cnt_full;
		sts.fill_last = cnt_full;
		sts.go_emit   = match;
		sts.em_last   = (em_slot_q == SLOT_CLK) && (em_idx_q == CNT_W'(WPM - 1));
	end

	// memory ports: stored words land in their slot, fill pads the rest with zero
	assign mem_we = (cmd.accept && wr_now) || cmd.fill;
	assign mem_wa = mem_addr(cmd.fill ? msg_slot_q : slot_now, cnt_q);
	assign mem_wd = cmd.fill ? '0 : nav_word;
	assign mem_ra = mem_addr(em_slot_q, em_idx_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q        <= CFG_W'(12);
			window_q     <= CFG_W'(36);
			cnt_q        <= '0;
			msg_wr_q     <= 1'b0;
			week_valid_q <= 1'b0;
			week_q       <= '0;
			slot_valid_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_GAP:    gap_q    <= cfg_data;
					CFG_WINDOW: window_q <= cfg_data;
					default:    ;
				endcase
			end
			if (cmd.accept) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '0)
					msg_wr_q <= w_wr;
			end
			if (cmd.fill)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.decide) begin
				cnt_q    <= '0;
				msg_wr_q <= 1'b0;
				if (!week_valid_q && is10) begin
					week_valid_q <= 1'b1;
					week_q       <= week_hdr_q;
				end
				if (stored)
					slot_valid_q[dec_slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (cnt_q == '0) begin
				type_q     <= w_type;
				prn_q      <= nav_word[21:16];
				tow_q      <= {nav_word[9:0], 7'b0};
				week_hdr_q <= '0;
				msg_slot_q <= w_slot;
			end else if (cnt_q == CNT_W'(1)) begin
				tow_q[6:0] <= nav_word[29:23];
				week_hdr_q <= nav_word[21:9];
			end
		end
		if (cmd.decide) begin
			if (stored)
				slot_time_q[dec_slot] <= t_new;
			out_status_q <= dec_status;
			out_word_q   <= '0;
			out_slot_q   <= '0;
			out_last_q   <= 1'b1;
			out_type_q   <= type_q;
			out_prn_q    <= prn_q;
			em_slot_q    <= SLOT_EPH1;
			em_idx_q     <= '0;
		end
		if (cmd.load_word) begin
			out_status_q <= ST_WORD;
			out_word_q   <= rdata_q;
			out_slot_q   <= em_slot_q;
			out_last_q   <= sts.em_last;
		end
		if (cmd.advance) begin
			if (em_idx_q == CNT_W'(WPM - 1)) begin
				em_idx_q  <= '0;
				em_slot_q <= em_slot_q + 1'b1;
			end else begin
				em_idx_q <= em_idx_q + 1'b1;
			end
		end
	end

	assign status      = out_status_q;
	assign out_word    = out_word_q;
	assign out_slot    = out_slot_q;
	assign out_last    = out_last_q;
	assign msg_type    = out_type_q;
	assign sat_prn     = out_prn_q;
	assign week_number = week_q;

endmodule

@@ design/cnav_message_set_assembler.sv @@
// Navigation message set assembler.
// Input channel (in_valid/in_ready): one 30-bit message word per transaction,
// word 1 first; word_last marks the final word, and the tenth word ends a
// message regardless. Words of a message are taken one per cycle.
// Output channel (out_valid/out_ready): one status transaction per message,
// or, when a type 3x message completes a matching set, 30 transactions that
// carry the stored type 10, type 11 and type 3x words in that order.
// After the final word, a stored message shorter than ten words has the rest
// of its slot padded with zeros, one word at a time, and then goes to the
// decision; the status is valid on the following cycle. An assembled set
// sends each word through a slot memory read, an output load and a
// handoff; input is held off meanwhile.
// Receiver stall: the output register holds its transaction; after a status
// transaction, input words keep being taken until the next message's decision,
// which waits for the register to empty.
// Reset (arst_n low): no week known, all slots empty, registers back to
// gap 12 s and window 36 s. No clearing pass is needed.
// Configuration writes (cfg_wr_en) take effect on the next edge.
`include "cnav_message_set_assembler_assert.svh"

module cnav_message_set_assembler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [cmsa_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cmsa_pkg::WORD_W-1:0]   nav_word,
	input  logic                          word_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [cmsa_pkg::WORD_W-1:0]   out_word,
	output logic [cmsa_pkg::SLOT_W-1:0]   out_slot,
	output logic                          out_last,
	output logic [cmsa_pkg::TYPE_W-1:0]   msg_type,
	output logic [cmsa_pkg::TYPE_W-1:0]   sat_prn,
	output logic [cmsa_pkg::WEEK_W-1:0]   week_number
);
	import cmsa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: word intake, slot padding, decision, word emission
	cmsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// header capture, slot memory, set checks and output register
	cmsa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.nav_word    (nav_word),
		.word_last   (word_last),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.out_word    (out_word),
		.out_slot    (out_slot),
		.out_last    (out_last),
		.msg_type    (msg_type),
		.sat_prn     (sat_prn),
		.week_number (week_number)
	);

	// no words taken while a set is being emitted
	`CMSA_ASSERT_IMP(a_no_intake_emit, out_valid && status == ST_WORD, !in_ready)
	// a status transaction is always the only one for its message
	`CMSA_ASSERT_IMP(a_status_last, out_valid && status != ST_WORD, out_last)
	// word and slot fields are zero outside assembled words
	`CMSA_ASSERT_IMP(a_status_zero, out_valid && status != ST_WORD,
		out_word == '0 && out_slot == '0)
	// the final emitted word hands control back to intake
	`CMSA_ASSERT_NXT(a_emit_done, out_valid && out_ready && out_last && status == ST_WORD,
		in_ready)

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cmsa_pkg::*;

	// One input word as the sender offers it.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} nav_item_t;

	// One output transaction as the assembler should produce it.
	typedef struct packed {
		status_t           st;
		logic [WORD_W-1:0] word;
		logic [SLOT_W-1:0] slot;
		logic              last;
		logic [TYPE_W-1:0] typ;
		logic [TYPE_W-1:0] prn;
		logic [WEEK_W-1:0] week;
	} set_result_t;

	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int QUIET_CYCLES = 30;   // zero padding plus decision, with margin

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_index = CFG_GAP;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [WORD_W-1:0] nav_word = '0;
	logic              word_last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [WORD_W-1:0] out_word;
	logic [SLOT_W-1:0] out_slot;
	logic              out_last;
	logic [TYPE_W-1:0] msg_type;
	logic [TYPE_W-1:0] sat_prn;
	logic [WEEK_W-1:0] week_number;

	cnav_message_set_assembler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.nav_word   (nav_word),
		.word_last  (word_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_word   (out_word),
		.out_slot   (out_slot),
		.out_last   (out_last),
		.msg_type   (msg_type),
		.sat_prn    (sat_prn),
		.week_number(week_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus and scoreboard storage.
	nav_item_t   word_feed[$];
	set_result_t owed_results[$];
	int          words_queued = 0;
	int          mismatches = 0;

	// Traffic shaping, set from the sequence, read at the falling edge.
	logic burst_mode = 1'b0;   // no idling on either side
	logic hold_req = 1'b0;     // ask for the one long receiver hold-off
	logic word_taken = 1'b0;   // input transaction completed at the last rising edge

	// ---------------------------------------------------------------------
	// Assembler mirror: register copies and message/slot state.
	// ---------------------------------------------------------------------
	logic [CFG_W-1:0]  gap_secs = 8'd12;
	logic [CFG_W-1:0]  window_secs = 8'd36;

	int                msg_pos = 0;
	logic              week_known = 1'b0;
	logic [WEEK_W-1:0] week_held = '0;
	logic [TOW_W-1:0]  hdr_tow = '0;
	logic [WEEK_W-1:0] hdr_week = '0;
	logic [TYPE_W-1:0] hdr_type = '0;
	logic [TYPE_W-1:0] hdr_prn = '0;
	logic [WORD_W-1:0] staging [WPM] = '{default: '0};
	logic [WORD_W-1:0] slot_mem [SLOT_CNT][WPM];
	logic [TIME_W-1:0] slot_secs [SLOT_CNT];
	logic [2:0]        slot_full = '0;

	function automatic void owe(status_t st, logic [WORD_W-1:0] w, logic [SLOT_W-1:0] s,
			logic fin);
		owed_results.push_back({st, w, s, fin, hdr_type, hdr_prn, week_held});
	endfunction

	// Advance the mirror by one accepted word; queue whatever the message end causes.
	task automatic track_nav_word(input logic [WORD_W-1:0] w, input logic fin);
		logic [TIME_W-1:0] secs;
		logic [WORD_W-1:0] msg [WPM];
		int                slot;
		int                d11;
		int                d3x;
		if (msg_pos == 0) begin
			hdr_tow = '0;
			hdr_week = '0;
			hdr_type = '0;
			hdr_prn = '0;
		end
		staging[msg_pos] = w;
		// word 1: type, PRN, TOW high bits; word 2: TOW low bits, week
		if (msg_pos == 0) begin
			hdr_type = w[15:10];
			hdr_prn = w[21:16];
			hdr_tow[16:7] = w[9:0];
		end else if (msg_pos == 1) begin
			hdr_week = w[21:9];
			hdr_tow[6:0] = w[29:23];
		end
		msg_pos++;
		// the tenth word closes the message whatever word_last says
		if (!fin && msg_pos < WPM)
			return;

		// the -12 s offset cancels in every difference, so keep TOW*6 only
		secs = hdr_tow * 20'd6;
		for (int i = 0; i < WPM; i++) begin
			msg[i] = staging[i];
			staging[i] = '0;   // missing words of a short message read as zero
		end
		msg_pos = 0;

		if (!week_known && hdr_type != MT_EPH1) begin
			owe(ST_DROP, '0, '0, 1'b1);
			return;
		end
		if (!week_known) begin
			week_held = hdr_week;
			week_known = 1'b1;
		end

		if (hdr_type == MT_EPH1)
			slot = SLOT_EPH1;
		else if (hdr_type == MT_EPH2)
			slot = SLOT_EPH2;
		else if (hdr_type >= MT_CLK_LO && hdr_type <= MT_CLK_HI)
			slot = SLOT_CLK;
		else begin
			owe(ST_OTHER, '0, '0, 1'b1);
			return;
		end
		for (int i = 0; i < WPM; i++)
			slot_mem[slot][i] = msg[i];
		slot_secs[slot] = secs;
		slot_full[slot] = 1'b1;

		if (slot != SLOT_CLK) begin
			owe(ST_STORED, '0, '0, 1'b1);
			return;
		end
		if (slot_full == 3'b111) begin
			// signed differences: a type 3x ahead of type 10 passes the window
			d11 = int'(slot_secs[SLOT_EPH2]) - int'(slot_secs[SLOT_EPH1]);
			d3x = int'(slot_secs[SLOT_CLK]) - int'(slot_secs[SLOT_EPH1]);
			if (d11 == int'(gap_secs) && d3x <= int'(window_secs)) begin
				for (int s = 0; s < SLOT_CNT; s++)
					for (int i = 0; i < WPM; i++)
						owe(ST_WORD, slot_mem[s][i], SLOT_W'(s),
							s == SLOT_CNT - 1 && i == WPM - 1);
				return;
			end
		end
		owe(ST_MISMATCH, '0, '0, 1'b1);
	endtask

	// ---------------------------------------------------------------------
	// Sender: offers queued words, drives at the falling edge, holds each
	// word steady until the transaction completes.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin : sender
		nav_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			if (word_feed.size() != 0 && (burst_mode || $urandom_range(99) >= 37)) begin
				nxt = word_feed.pop_front();
				in_valid <= 1'b1;
				nav_word <= nxt.word;
				word_last <= nxt.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random ready, plus one long hold-off counted here.
	int   hold_left = 0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= burst_mode || ($urandom_range(99) >= 37);
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge. Input transactions
	// feed the mirror, output transactions are checked in order.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		set_result_t want;
		if (arst_n) begin
			word_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				track_nav_word(nav_word, word_last);
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: status %0d word %h slot %0d last %b",
							status, out_word, out_slot, out_last);
				end else begin
					want = owed_results.pop_front();
					if (status !== want.st || out_word !== want.word ||
							out_slot !== want.slot || out_last !== want.last ||
							msg_type !== want.typ || sat_prn !== want.prn ||
							week_number !== want.week) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp st %0d word %h slot %0d last %b ",
								"type %0d prn %0d week %0d / got st %0d word %h slot %0d ",
								"last %b type %0d prn %0d week %0d"},
								want.st, want.word, want.slot, want.last, want.typ,
								want.prn, want.week, status, out_word, out_slot,
								out_last, msg_type, sat_prn, week_number);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers.
	// ---------------------------------------------------------------------

	// Queue one message of len words; header fields go into words 1 and 2,
	// everything else is random. A full-length message ends with word_last
	// = tail_flag, so 0 gives an over-long message closed by the word count.
	task automatic queue_message(input logic [TYPE_W-1:0] typ, input logic [TYPE_W-1:0] prn,
			input logic [TOW_W-1:0] tow, input logic [WEEK_W-1:0] wk, input int len,
			input logic tail_flag);
		logic [WORD_W-1:0] w;
		logic              fin;
		for (int i = 0; i < len; i++) begin
			w = WORD_W'($urandom);
			if (i == 0)
				w[21:0] = {prn, typ, tow[16:7]};
			else if (i == 1) begin
				w[29:23] = tow[6:0];
				w[21:9] = wk;
			end
			fin = (i == len - 1) && (len < WPM || tail_flag);
			word_feed.push_back({w, fin});
			words_queued++;
		end
	endtask

	// Mostly messages of two to WPM words, a share of them full-size; a few one-word ones.
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 1;
		if (r < 25)
			return WPM;
		return $urandom_range(2, WPM);
	endfunction

	// One type 10 / 11 / 3x set aimed at the current gap and window, with
	// some sets broken: slot skipped, gap off, 3x out of window, stray types.
	task automatic queue_set();
		logic [TOW_W-1:0]  base;
		logic [TYPE_W-1:0] prn;
		logic [WEEK_W-1:0] wk;
		int                roll;
		int                step;
		int                d;
		roll = $urandom_range(99);
		base = (roll < 6) ? '0 : (roll < 12) ? '1 : TOW_W'($urandom);
		prn = TYPE_W'($urandom);
		wk = WEEK_W'($urandom);
		// a gap that is no multiple of 6 s can never match
		step = (gap_secs % 6 == 0) ? int'(gap_secs) / 6 : $urandom_range(0, 3);
		if ($urandom_range(99) < 15)
			step = step + $urandom_range(1, 2);
		d = $urandom_range(0, int'(window_secs) / 6 + 3) - 2;

		if ($urandom_range(99) < 15)
			queue_message(TYPE_W'($urandom), prn, TOW_W'($urandom), wk, pick_len(),
				$urandom_range(1));
		if ($urandom_range(99) >= 8)
			queue_message(MT_EPH1, prn, base, wk, pick_len(), $urandom_range(1));
		if ($urandom_range(99) < 12)
			queue_message(TYPE_W'($urandom), prn, TOW_W'($urandom), wk, pick_len(),
				$urandom_range(1));
		if ($urandom_range(99) >= 8)
			queue_message(MT_EPH2, prn, TOW_W'(base + step), wk, pick_len(),
				$urandom_range(1));
		queue_message(MT_CLK_LO + 3'($urandom), prn, TOW_W'(base + d), wk, pick_len(),
			$urandom_range(1));
	endtask

	task automatic fill_sets(input int budget);
		int start;
		@(posedge clk);
		start = words_queued;
		while (words_queued - start < budget)
			queue_set();
	endtask

	// The sequence waits here until every queued word is taken and every
	// expected transaction has come out, then lets the block go quiet.
	task automatic settle();
		do
			@(negedge clk);
		while (word_feed.size() != 0 || in_valid || owed_results.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_GAP)
			gap_secs = val;
		else
			window_secs = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Sequence.
	// ---------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset registers (gap 12 s, window 36 s).
		@(posedge clk);
		// all-zero one-word message before any week: dropped, word 2 missing
		word_feed.push_back({{WORD_W{1'b0}}, 1'b1});
		words_queued++;
		// type 10, TOW 1 (t = 6 s), max week latched
		queue_message(MT_EPH1, '1, 17'd1, '1, 2, 1'b1);
		// type 11, TOW 3: exactly the 12 s gap
		queue_message(MT_EPH2, '0, 17'd3, '0, 3, 1'b1);
		// type 3x at TOW 0, ahead of type 10; over-long, closed by the count
		queue_message(MT_CLK_LO + 6'd3, 6'd17, '0, '0, WPM, 1'b0);
		// all-ones word as a one-word message: type out of range
		word_feed.push_back({{WORD_W{1'b1}}, 1'b1});
		words_queued++;
		// far past the window
		queue_message(MT_CLK_HI, 6'd5, 17'd100, '0, 2, 1'b1);
		// exactly on the window edge, then one step past it
		queue_message(MT_CLK_LO, 6'd9, 17'd7, '0, 2, 1'b1);
		queue_message(MT_CLK_LO + 6'd1, 6'd9, 17'd8, '0, 2, 1'b1);
		settle();

		// Reset registers again; receiver stalls long while words keep coming.
		hold_req <= 1'b1;
		fill_sets(40);
		settle();

		// Zero gap, zero window.
		write_reg(CFG_GAP, '0);
		write_reg(CFG_WINDOW, '0);
		fill_sets(25);
		settle();

		// Top values; no idling on either side through this stretch.
		write_reg(CFG_GAP, '1);
		write_reg(CFG_WINDOW, '1);
		burst_mode <= 1'b1;
		fill_sets(25);
		settle();
		burst_mode <= 1'b0;

		// Matchable gaps with random windows.
		write_reg(CFG_GAP, CFG_W'(6 * $urandom_range(0, 10)));
		write_reg(CFG_WINDOW, CFG_W'($urandom_range(0, 255)));
		fill_sets(25);
		settle();

		write_reg(CFG_WINDOW, CFG_W'($urandom_range(0, 255)));
		write_reg(CFG_GAP, CFG_W'(6 * $urandom_range(0, 42)));
		fill_sets(25);
		settle();

		if (mismatches == 0 && owed_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/cmsa_pkg.sv
design/cmsa_ctrl.sv
design/cmsa_dp.sv
design/cnav_message_set_assembler.sv
dv/testbench.sv
